// ===== hw/rtl/c8kbm_pkg.sv =====
// Package for the 8 KB bank mapper: widths, address constants, routing codes
// and the bank register write command. No dependencies.
package c8kbm_pkg;

  localparam int unsigned PAGE_BITS  = 10;
  localparam int unsigned WINDOWS    = 6;
  localparam int unsigned SLOT_W     = $clog2(WINDOWS);
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned MASK_W     = 10;
  localparam int unsigned OFFSET_W   = 13;
  localparam int unsigned ROM_ADDR_W = 23;
  localparam int unsigned OUTER_W    = 8;
  // Page arithmetic width: outer bank * 4 plus twice a 5-bit field, and room
  // for the widest page.
  localparam int unsigned SUM_W      = 13;

  localparam logic [ADDR_W-1:0] SEL_FORCE  = 16'h4010;
  localparam logic [ADDR_W-1:0] SEL_OUTER  = 16'hFFF5;
  localparam logic [ADDR_W-1:0] SEL_PAIR_A = 16'hFFFE;
  localparam logic [ADDR_W-1:0] SEL_PAIR_B = 16'hFFFF;
  localparam logic [ADDR_W-1:0] RAM_BASE   = 16'hC000;

  localparam logic [4:0]         DMASK_WIDE   = 5'h1F;
  localparam logic [4:0]         DMASK_NARROW = 5'h0F;
  localparam logic [OUTER_W-1:0] OUTER_WIDE   = 8'h10;

  localparam logic [MASK_W-1:0] ROM_MASK_RESET = 10'd7;

  typedef enum logic [1:0] {
    TGT_ROM_READ  = 2'd0,
    TGT_RAM_READ  = 2'd1,
    TGT_RAM_WRITE = 2'd2
  } target_e;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bank_cmd_t;

  function automatic logic [PAGE_BITS-1:0] cut_page(logic [SUM_W-1:0] p,
                                                    logic [MASK_W-1:0] mask);
    logic [SUM_W-1:0] t;
    t = p & SUM_W'(mask);
    return t[PAGE_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/cartridge_8k_bank_mapper.sv =====
// Top level of the 8 KB cartridge bank mapper: input register, routing
// logic and result register around c8kbm_bank_regs. Uses c8kbm_pkg.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid_i/in_stall_o    op_i, bus_address_i, write_data_i
//   out       from block out_valid_o/out_stall_i  target_o, rom_address_o,
//                                                 ram_offset_o, ram_data_o
//   cfg       to block   cfg_valid_i/cfg_ready_o  cfg_data_i (rom_bank_mask)
//
// One access per cycle while the input is not stalled; a result is presented
// once its transaction has passed the input register, then the result
// register, set by the single routing stage.
// Writes below 0xC000 only update the bank registers and give no result.
// Reset clears both stages, the outer bank to zero, pages to 0,1,2,3,2,3 and
// the ROM bank mask to 7. A stalled output holds the result register; the
// input stalls only when its held access has a result with nowhere to go.
module cartridge_8k_bank_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [c8kbm_pkg::ADDR_W-1:0]        bus_address_i,
  input  logic [c8kbm_pkg::DATA_W-1:0]        write_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          target_o,
  output logic [c8kbm_pkg::ROM_ADDR_W-1:0]    rom_address_o,
  output logic [c8kbm_pkg::OFFSET_W-1:0]      ram_offset_o,
  output logic [c8kbm_pkg::DATA_W-1:0]        ram_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [c8kbm_pkg::MASK_W-1:0]        cfg_data_i
);

  logic                              in_valid_q, in_valid_d;
  c8kbm_pkg::op_e                    in_op_q;
  logic [c8kbm_pkg::ADDR_W-1:0]      in_addr_q;
  logic [c8kbm_pkg::DATA_W-1:0]      in_data_q;

  logic                              out_valid_q, out_valid_d;
  c8kbm_pkg::target_e                out_target_q, out_target_d;
  logic [c8kbm_pkg::ROM_ADDR_W-1:0]  out_rom_q, out_rom_d;
  logic [c8kbm_pkg::OFFSET_W-1:0]    out_off_q, out_off_d;
  logic [c8kbm_pkg::DATA_W-1:0]      out_data_q, out_data_d;

  logic [c8kbm_pkg::MASK_W-1:0]      rom_mask_q;

  logic                              in_ram_space, has_result, out_free, advance, accept;
  c8kbm_pkg::bank_cmd_t              bank_cmd;
  logic [c8kbm_pkg::PAGE_BITS-1:0]   page;
  logic [c8kbm_pkg::OFFSET_W-1:0]    offset;

  assign in_ram_space = (in_addr_q >= c8kbm_pkg::RAM_BASE);
  assign offset       = in_addr_q[c8kbm_pkg::OFFSET_W-1:0];
  // A write below RAM space retires without a result.
  assign has_result   = !(in_op_q == c8kbm_pkg::OP_WRITE && !in_ram_space);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign advance      = in_valid_q && (out_free || !has_result);
  assign in_stall_o   = in_valid_q && !advance;
  assign accept       = in_valid_i && !in_stall_o;
  assign cfg_ready_o  = 1'b1;

  always_comb begin
    bank_cmd.en   = advance && (in_op_q == c8kbm_pkg::OP_WRITE);
    bank_cmd.addr = in_addr_q;
    bank_cmd.data = in_data_q;
  end

  c8kbm_bank_regs u_bank_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (bank_cmd),
    .rom_mask_i (rom_mask_q),
    .slot_i     (in_addr_q[c8kbm_pkg::ADDR_W-1 -: c8kbm_pkg::SLOT_W]),
    .page_o     (page)
  );

  always_comb begin
    in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

    out_target_d = c8kbm_pkg::TGT_ROM_READ;
    out_rom_d    = '0;
    out_off_d    = '0;
    out_data_d   = '0;
    if (in_op_q == c8kbm_pkg::OP_WRITE) begin
      out_target_d = c8kbm_pkg::TGT_RAM_WRITE;
      out_off_d    = offset;
      out_data_d   = in_data_q;
    end else if (in_ram_space) begin
      out_target_d = c8kbm_pkg::TGT_RAM_READ;
      out_off_d    = offset;
    end else begin
      out_rom_d    = c8kbm_pkg::ROM_ADDR_W'({page, offset});
    end

    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rom_mask_q  <= c8kbm_pkg::ROM_MASK_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        rom_mask_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= c8kbm_pkg::op_e'(op_i);
      in_addr_q <= bus_address_i;
      in_data_q <= write_data_i;
    end
    if (advance && has_result) begin
      out_target_q <= out_target_d;
      out_rom_q    <= out_rom_d;
      out_off_q    <= out_off_d;
      out_data_q   <= out_data_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = out_target_q;
  assign rom_address_o = out_rom_q;
  assign ram_offset_o  = out_off_q;
  assign ram_data_o    = out_data_q;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked held access");

  a_rom_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o == c8kbm_pkg::TGT_ROM_READ)
      |-> (ram_offset_o == '0 && ram_data_o == '0))
    else $error("ROM read carries RAM fields");

  a_ram_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o != c8kbm_pkg::TGT_ROM_READ) |-> (rom_address_o == '0))
    else $error("RAM access carries a ROM address");

  a_read_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o == c8kbm_pkg::TGT_RAM_READ) |-> (ram_data_o == '0))
    else $error("RAM read carries write data");
`endif

endmodule

// ===== hw/rtl/c8kbm_bank_regs.sv =====
// Window page and outer bank registers of the 8 KB bank mapper, with their
// write decode and the page lookup for ROM reads. Uses c8kbm_pkg.
module c8kbm_bank_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  c8kbm_pkg::bank_cmd_t               cmd_i,
  input  logic [c8kbm_pkg::MASK_W-1:0]       rom_mask_i,
  input  logic [c8kbm_pkg::SLOT_W-1:0]       slot_i,
  output logic [c8kbm_pkg::PAGE_BITS-1:0]    page_o
);

  logic [c8kbm_pkg::PAGE_BITS-1:0] page_q [c8kbm_pkg::WINDOWS];
  logic [c8kbm_pkg::PAGE_BITS-1:0] page_d [c8kbm_pkg::WINDOWS];
  logic [c8kbm_pkg::OUTER_W-1:0]   outer_q, outer_d;

  logic [c8kbm_pkg::ADDR_W-1:0] sel;
  logic [4:0]                   dmask;
  logic [c8kbm_pkg::SUM_W-1:0]  old_base, new_base, first;

  always_comb begin
    sel      = cmd_i.addr | c8kbm_pkg::SEL_FORCE;
    // Data mask follows the outer bank as it was before this write.
    dmask    = (outer_q >= c8kbm_pkg::OUTER_WIDE) ? c8kbm_pkg::DMASK_WIDE
                                                  : c8kbm_pkg::DMASK_NARROW;
    old_base = c8kbm_pkg::SUM_W'({outer_q, 2'b00});
    new_base = c8kbm_pkg::SUM_W'({cmd_i.data, 2'b00});
    first    = old_base + c8kbm_pkg::SUM_W'({cmd_i.data[4:0] & dmask, 1'b0});

    outer_d = outer_q;
    page_d  = page_q;
    if (cmd_i.en) begin
      if (sel == c8kbm_pkg::SEL_OUTER) begin
        outer_d   = cmd_i.data;
        page_d[0] = c8kbm_pkg::cut_page(new_base, rom_mask_i);
        page_d[1] = c8kbm_pkg::cut_page(new_base + c8kbm_pkg::SUM_W'(1), rom_mask_i);
        page_d[2] = c8kbm_pkg::cut_page(new_base + c8kbm_pkg::SUM_W'(2), rom_mask_i);
        page_d[3] = c8kbm_pkg::cut_page(new_base + c8kbm_pkg::SUM_W'(3), rom_mask_i);
        page_d[4] = c8kbm_pkg::cut_page(new_base + c8kbm_pkg::SUM_W'(2), rom_mask_i);
        page_d[5] = c8kbm_pkg::cut_page(new_base + c8kbm_pkg::SUM_W'(3), rom_mask_i);
      end else if (sel == c8kbm_pkg::SEL_PAIR_A) begin
        page_d[2] = c8kbm_pkg::cut_page(first, rom_mask_i);
        page_d[3] = c8kbm_pkg::cut_page(first + c8kbm_pkg::SUM_W'(1), rom_mask_i);
      end else if (sel == c8kbm_pkg::SEL_PAIR_B) begin
        page_d[4] = c8kbm_pkg::cut_page(first, rom_mask_i);
        page_d[5] = c8kbm_pkg::cut_page(first + c8kbm_pkg::SUM_W'(1), rom_mask_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q   <= '0;
      page_q[0] <= c8kbm_pkg::PAGE_BITS'(0);
      page_q[1] <= c8kbm_pkg::PAGE_BITS'(1);
      page_q[2] <= c8kbm_pkg::PAGE_BITS'(2);
      page_q[3] <= c8kbm_pkg::PAGE_BITS'(3);
      page_q[4] <= c8kbm_pkg::PAGE_BITS'(2);
      page_q[5] <= c8kbm_pkg::PAGE_BITS'(3);
    end else begin
      outer_q <= outer_d;
      page_q  <= page_d;
    end
  end

  // Slots six and seven belong to RAM space and never reach a ROM read.
  assign page_o = (32'(slot_i) < c8kbm_pkg::WINDOWS) ? page_q[slot_i] : '0;

endmodule
